// ===== rtl/asc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package asc_pkg;

  localparam int PIX_DEPTH  = 6144;
  localparam int ATTR_DEPTH = 768;
  localparam int PIX_AW     = 13;
  localparam int ATTR_AW    = 10;
  localparam int COPY_DW    = 8;
  localparam int ROWS       = 24;
  localparam int FLASH_W    = 5;
  localparam int IN_W       = 32;
  localparam int OUT_W      = 48;

  typedef enum logic {
    CMD_DECODE = 1'b0,
    CMD_EOF    = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               pix_we;
    logic [PIX_AW-1:0]  pix_addr;
    logic [COPY_DW-1:0] pix_data;
    logic               attr_we;
    logic [ATTR_AW-1:0] attr_addr;
    logic [COPY_DW-1:0] attr_data;
  } copy_wr_t;

  // interleaved screen offset: row[4:3], line, row[2:0], col
  function automatic logic [PIX_AW-1:0] pix_offset(input logic [4:0] row,
                                                   input logic [2:0] line,
                                                   input logic [4:0] col);
    pix_offset = {row[4:3], line, row[2:0], col};
  endfunction

  function automatic logic [ATTR_AW-1:0] attr_offset(input logic [4:0] row,
                                                     input logic [4:0] col);
    attr_offset = {row, col};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/asc_copy_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module asc_copy_mem #(
  parameter int DEPTH = 768,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/asc_cell_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none

module asc_cell_pipe import asc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_fire,
  input  wire logic [IN_W-1:0]    in_data,
  input  wire logic               in_cmd,
  output logic                    in_ready,
  input  wire logic [COPY_DW-1:0] pix_rd,
  input  wire logic [COPY_DW-1:0] attr_rd,
  output copy_wr_t                wr,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [OUT_W-1:0]        out_data
);

  logic               s1_valid;
  cmd_t               s1_cmd;
  logic [4:0]         s1_col;
  logic [4:0]         s1_row;
  logic [2:0]         s1_line;
  logic [7:0]         s1_attr;
  logic [7:0]         s1_pix;

  logic [FLASH_W-1:0] flash_count;
  logic               first_frame;
  logic               dirty_acc;

  // last write to each copy, for an item read in the same cycle as that write
  logic               pw_valid;
  logic [PIX_AW-1:0]  pw_addr;
  logic [COPY_DW-1:0] pw_data;
  logic               aw_valid;
  logic [ATTR_AW-1:0] aw_addr;
  logic [COPY_DW-1:0] aw_data;

  logic               adv;
  logic               swap;
  logic [2:0]         ink;
  logic [2:0]         paper;
  logic [7:0]         attr_sw;
  logic [3:0]         ink_idx;
  logic [3:0]         paper_idx;
  logic [PIX_AW-1:0]  addr;
  logic [ATTR_AW-1:0] aidx;
  logic               in_range;
  logic [COPY_DW-1:0] pix_old;
  logic [COPY_DW-1:0] attr_old;
  logic               changed;
  logic               dirty_next;
  logic [OUT_W-1:0]   result;
  logic [31:0]        pixels;

  assign adv      = !out_valid || out_ready;
  assign in_ready = !s1_valid || adv;

  always_comb begin
    swap      = s1_attr[7] && !flash_count[FLASH_W-1];
    ink       = swap ? s1_attr[5:3] : s1_attr[2:0];
    paper     = swap ? s1_attr[2:0] : s1_attr[5:3];
    attr_sw   = {s1_attr[7:6], paper, ink};
    ink_idx   = {s1_attr[6], ink};
    paper_idx = {s1_attr[6], paper};
    addr      = pix_offset(s1_row, s1_line, s1_col);
    aidx      = attr_offset(s1_row, s1_col);
    in_range  = s1_row < 5'(ROWS);
    pix_old   = (pw_valid && pw_addr == addr) ? pw_data : pix_rd;
    attr_old  = (aw_valid && aw_addr == aidx) ? aw_data : attr_rd;
    changed   = in_range && (pix_old != s1_pix || attr_old != attr_sw);
    dirty_next = ((s1_col == 5'd0 && s1_line == 3'd0) ? 1'b0 : dirty_acc) || changed;
    for (int k = 0; k < 8; k++) begin
      pixels[4*k +: 4] = s1_pix[7-k] ? ink_idx : paper_idx;
    end
    result = {2'b00, dirty_next || first_frame, addr, pixels};
  end

  always_comb begin
    wr.pix_we    = s1_valid && adv && s1_cmd == CMD_DECODE && in_range;
    wr.pix_addr  = addr;
    wr.pix_data  = s1_pix;
    wr.attr_we   = wr.pix_we;
    wr.attr_addr = aidx;
    wr.attr_data = attr_sw;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd  <= cmd_t'(in_cmd);
      s1_col  <= in_data[4:0];
      s1_row  <= in_data[9:5];
      s1_line <= in_data[12:10];
      s1_attr <= in_data[20:13];
      s1_pix  <= in_data[28:21];
    end
    if (wr.pix_we) begin
      pw_addr <= wr.pix_addr;
      pw_data <= wr.pix_data;
    end
    if (wr.attr_we) begin
      aw_addr <= wr.attr_addr;
      aw_data <= wr.attr_data;
    end
    if (adv) begin
      out_data <= (s1_cmd == CMD_EOF) ? '0 : result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      flash_count <= '0;
      first_frame <= 1'b1;
      dirty_acc   <= 1'b0;
      pw_valid    <= 1'b0;
      aw_valid    <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= s1_valid;
      end
      if (wr.pix_we) begin
        pw_valid <= 1'b1;
      end
      if (wr.attr_we) begin
        aw_valid <= 1'b1;
      end
      if (s1_valid && adv) begin
        if (s1_cmd == CMD_EOF) begin
          flash_count <= flash_count + 1'b1;
          first_frame <= 1'b0;
          dirty_acc   <= 1'b0;
        end else begin
          dirty_acc <= dirty_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/attribute_screen_cell_decoder.sv =====
// attribute screen cell decoder
// s channel: one item per pixel row of one character cell, or an end-of-frame
// tick (s_tuser high). m channel: one item per accepted input item, in order:
// eight 4-bit colour indices, the interleaved screen offset and the running
// dirty flag of the current character row. an end-of-frame item returns zeros.
// throughput: one item per cycle while m_tready is high; the pixel and
// attribute copies are single-port-read, single-port-write block memories
// read at accept and written back as the item leaves the middle stage, with
// a bypass of the last write covering back-to-back items on the same cell.
// reset: both copies are cleared by a sweep over the 6144 pixel addresses,
// one entry per cycle; s_tready stays low during the sweep. flash timer and
// dirty flag reset to zero, the first-frame mark to one (every row reads dirty).
// when m_tready is low the result register holds, the middle stage holds
// behind it and s_tready drops once both are full.
`timescale 1ns / 1ps
`default_nettype none

module attribute_screen_cell_decoder import asc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // cell_col, cell_row, line_in_cell, attr_byte,
                                           // pixel_byte, zero pad
  input  wire logic             s_tuser,   // cmd
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata    // pixel_0 .. pixel_7, pixel_address,
                                           // row_dirty, zero pad
);

  logic               clearing;
  logic [PIX_AW-1:0]  clr_addr;
  logic               pipe_ready;
  logic               in_fire;
  copy_wr_t           wr;
  logic [COPY_DW-1:0] pix_rd;
  logic [COPY_DW-1:0] attr_rd;
  logic               pix_we;
  logic [PIX_AW-1:0]  pix_waddr;
  logic [COPY_DW-1:0] pix_wdata;
  logic               attr_we;
  logic [ATTR_AW-1:0] attr_waddr;
  logic [COPY_DW-1:0] attr_wdata;

  assign s_tready = !clearing && pipe_ready;
  assign in_fire  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == PIX_AW'(PIX_DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_comb begin
    pix_we     = clearing || wr.pix_we;
    pix_waddr  = clearing ? clr_addr : wr.pix_addr;
    pix_wdata  = clearing ? '0 : wr.pix_data;
    attr_we    = clearing ? (clr_addr < PIX_AW'(ATTR_DEPTH)) : wr.attr_we;
    attr_waddr = clearing ? clr_addr[ATTR_AW-1:0] : wr.attr_addr;
    attr_wdata = clearing ? '0 : wr.attr_data;
  end

  asc_copy_mem #(
    .DEPTH (PIX_DEPTH),
    .AW    (PIX_AW),
    .DW    (COPY_DW)
  ) u_pix_copy (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (pix_wdata),
    .re    (in_fire),
    .raddr (pix_offset(s_tdata[9:5], s_tdata[12:10], s_tdata[4:0])),
    .rdata (pix_rd)
  );

  asc_copy_mem #(
    .DEPTH (ATTR_DEPTH),
    .AW    (ATTR_AW),
    .DW    (COPY_DW)
  ) u_attr_copy (
    .clk   (clk),
    .we    (attr_we),
    .waddr (attr_waddr),
    .wdata (attr_wdata),
    .re    (in_fire),
    .raddr (attr_offset(s_tdata[9:5], s_tdata[4:0])),
    .rdata (attr_rd)
  );

  asc_cell_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_data   (s_tdata),
    .in_cmd    (s_tuser),
    .in_ready  (pipe_ready),
    .pix_rd    (pix_rd),
    .attr_rd   (attr_rd),
    .wr        (wr),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_fire)
    else $error("item accepted during copy clear");

  a_no_pipe_write_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !wr.pix_we && !wr.attr_we)
    else $error("copy write from pipe during clear");

  a_pix_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr.pix_we |-> wr.pix_addr < PIX_AW'(PIX_DEPTH) && wr.attr_addr < ATTR_AW'(ATTR_DEPTH))
    else $error("copy write outside screen");

endmodule

`default_nettype wire

// ===== bench/tb_attribute_screen_cell_decoder.sv =====
`timescale 1ns / 1ps

module tb_attribute_screen_cell_decoder;
  import asc_pkg::*;

  localparam int FLASH_HALF    = 16;
  localparam int IDLE_LIMIT    = 20000;
  localparam int ITEM_TARGET   = 1500;
  localparam int CALM_FROM     = 1300;
  localparam int MAX_REPORTS   = 10;
  localparam int TAIL_CYCLES   = 8;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;   // cell_col, cell_row, line_in_cell, attr_byte, pixel_byte, zero pad
  logic             s_tuser;   // cmd
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;   // pixel_0 .. pixel_7, pixel_address, row_dirty, zero pad

  attribute_screen_cell_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // predictor state
  logic [COPY_DW-1:0] pix_mirror  [PIX_DEPTH];
  logic [COPY_DW-1:0] attr_mirror [ATTR_DEPTH];
  logic [7:0]         last_raw_attr [ATTR_DEPTH];
  logic [FLASH_W-1:0] flash_ctr;
  logic               first_pass;
  logic               row_change;

  logic [OUT_W-1:0]   expected_rows [$];
  logic [OUT_W-1:0]   want;
  int                 item_count;
  int                 mismatch_count;
  int                 stall_left;
  bit                 calm;
  bit                 bad;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [PIX_AW-1:0] screen_offset(logic [4:0] row, logic [2:0] line,
                                                      logic [4:0] col);
    int scan;
    scan = ((int'(row) * 8) & 'hC0) + int'(line) * 8 + (int'(row) & 7);
    return PIX_AW'(32 * scan + int'(col));
  endfunction

  function automatic logic [OUT_W-1:0] decode_row(cmd_t c, logic [4:0] col, logic [4:0] row,
                                                  logic [2:0] line, logic [7:0] attr,
                                                  logic [7:0] pix);
    logic [2:0]         ink;
    logic [2:0]         paper;
    logic [7:0]         eff_attr;
    logic [3:0]         ink_idx;
    logic [3:0]         paper_idx;
    logic [PIX_AW-1:0]  addr;
    logic [ATTR_AW-1:0] cell_idx;
    logic [OUT_W-1:0]   res;
    logic               changed;
    res     = '0;
    changed = 1'b0;
    if (c == CMD_EOF) begin
      flash_ctr  = flash_ctr + 1'b1;
      first_pass = 1'b0;
      row_change = 1'b0;
      return res;
    end
    ink      = attr[2:0];
    paper    = attr[5:3];
    eff_attr = attr;
    if (attr[7] && flash_ctr < FLASH_HALF) begin
      ink      = attr[5:3];
      paper    = attr[2:0];
      eff_attr = {attr[7:6], attr[2:0], attr[5:3]};
    end
    addr = screen_offset(row, line, col);
    if (col == 0 && line == 0) row_change = 1'b0;
    if (row < ROWS) begin
      cell_idx = ATTR_AW'(32 * int'(row) + int'(col));
      if (attr_mirror[cell_idx] != eff_attr) begin
        attr_mirror[cell_idx] = eff_attr;
        changed = 1'b1;
      end
      if (pix_mirror[addr] != pix) begin
        pix_mirror[addr] = pix;
        changed = 1'b1;
      end
    end
    if (changed) row_change = 1'b1;
    ink_idx   = {eff_attr[6], ink};
    paper_idx = {eff_attr[6], paper};
    for (int k = 0; k < 8; k++) res[4*k +: 4] = pix[7-k] ? ink_idx : paper_idx;
    res[32 +: PIX_AW] = addr;
    res[32 + PIX_AW]  = row_change | first_pass;
    return res;
  endfunction

  task automatic send_item(cmd_t c, logic [4:0] col, logic [4:0] row, logic [2:0] line,
                           logic [7:0] attr, logic [7:0] pix);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= {3'b000, pix, attr, line, row, col};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_rows.push_back(decode_row(c, col, row, line, attr, pix));
    item_count++;
  endtask

  // fields of a tick are don't-care, so they carry random content
  task automatic send_tick();
    send_item(CMD_EOF, 5'($urandom), 5'($urandom), 3'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_first_frame_extremes();
    send_item(CMD_DECODE, 5'd0, 5'd0, 3'd0, 8'h00, 8'h00);
    send_item(CMD_DECODE, 5'd31, 5'd23, 3'd7, 8'hFF, 8'hFF);
    send_item(CMD_DECODE, 5'd0, 5'd0, 3'd0, 8'h47, 8'hA5);
  endtask

  task automatic test_flash_swap();
    send_item(CMD_DECODE, 5'd4, 5'd2, 3'd1, 8'h8A, 8'hF0);
    send_item(CMD_DECODE, 5'd5, 5'd2, 3'd1, 8'h0A, 8'hF0);
    send_item(CMD_DECODE, 5'd6, 5'd2, 3'd1, 8'hC1, 8'h3C);
  endtask

  task automatic test_end_of_frame();
    send_tick();
  endtask

  task automatic test_row_start_clear();
    send_item(CMD_DECODE, 5'd0, 5'd5, 3'd0, 8'h00, 8'h00);
    send_item(CMD_DECODE, 5'd1, 5'd5, 3'd0, 8'h00, 8'h11);
    send_item(CMD_DECODE, 5'd2, 5'd5, 3'd0, 8'h00, 8'h00);
    send_item(CMD_DECODE, 5'd0, 5'd5, 3'd0, 8'h00, 8'h00);
    send_item(CMD_DECODE, 5'd0, 5'd5, 3'd0, 8'h00, 8'h81);
  endtask

  // changed attribute seen on several lines of one cell
  task automatic test_attr_lines();
    send_item(CMD_DECODE, 5'd0, 5'd7, 3'd0, 8'h00, 8'h00);
    for (int ln = 1; ln < 4; ln++) send_item(CMD_DECODE, 5'd3, 5'd7, 3'(ln), 8'h3C, 8'h00);
  endtask

  task automatic test_rows_out_of_range();
    send_tick();
    send_item(CMD_DECODE, 5'd0, 5'd24, 3'd0, 8'hFF, 8'hFF);
    send_item(CMD_DECODE, 5'd31, 5'd31, 3'd7, 8'h6D, 8'h5A);
    send_item(CMD_DECODE, 5'd0, 5'd0, 3'd0, 8'h47, 8'hA5);
  endtask

  // one character row, screen order, over a few cells
  task automatic send_row_burst();
    logic [4:0]         row;
    logic [4:0]         col0;
    int                 ncols;
    logic [7:0]         attr [4];
    logic [7:0]         pix;
    logic [4:0]         col;
    logic [ATTR_AW-1:0] cell_idx;
    row   = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31)) : 5'($urandom_range(0, 23));
    col0  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 27)) : 5'd0;
    ncols = $urandom_range(1, 4);
    for (int c = 0; c < ncols; c++) begin
      col      = col0 + 5'(c);
      cell_idx = ATTR_AW'(32 * int'(row) + int'(col));
      if (row < ROWS && $urandom_range(0, 1) == 0) attr[c] = last_raw_attr[cell_idx];
      else attr[c] = 8'($urandom);
      if (row < ROWS) last_raw_attr[cell_idx] = attr[c];
    end
    for (int ln = 0; ln < 8; ln++) begin
      for (int c = 0; c < ncols; c++) begin
        col = col0 + 5'(c);
        if (row < ROWS && $urandom_range(0, 1) == 0)
          pix = pix_mirror[screen_offset(row, 3'(ln), col)];
        else
          pix = 8'($urandom);
        send_item(CMD_DECODE, col, row, 3'(ln), attr[c], pix);
      end
    end
  endtask

  task automatic test_random_frames();
    int pick;
    while (item_count < ITEM_TARGET) begin
      if (item_count >= CALM_FROM) calm = 1'b1;
      pick = $urandom_range(0, 11);
      if (pick < 4) send_tick();
      else if (pick < 9) send_row_burst();
      else send_item(CMD_DECODE, 5'($urandom), 5'($urandom), 3'($urandom), 8'($urandom),
                     8'($urandom));
    end
  endtask

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 6);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_rows.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result item %h", m_tdata);
      end else begin
        want = expected_rows.pop_front();
        bad  = 1'b0;
        for (int k = 0; k < 8; k++) if (m_tdata[4*k +: 4] != want[4*k +: 4]) bad = 1'b1;
        if (m_tdata[32 +: PIX_AW] != want[32 +: PIX_AW]) bad = 1'b1;
        if (m_tdata[32 + PIX_AW] != want[32 + PIX_AW]) bad = 1'b1;
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: expected pixels %h addr %0d dirty %0b, got pixels %h addr %0d dirty %0b",
                     want[31:0], want[32 +: PIX_AW], want[32 + PIX_AW],
                     m_tdata[31:0], m_tdata[32 +: PIX_AW], m_tdata[32 + PIX_AW]);
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tuser        = 1'b0;
    s_tdata        = '0;
    stall_left     = 0;
    calm           = 1'b0;
    item_count     = 0;
    mismatch_count = 0;
    flash_ctr      = '0;
    first_pass     = 1'b1;
    row_change     = 1'b0;
    for (int i = 0; i < PIX_DEPTH; i++) pix_mirror[i] = '0;
    for (int i = 0; i < ATTR_DEPTH; i++) begin
      attr_mirror[i]   = '0;
      last_raw_attr[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_first_frame_extremes();
    test_flash_swap();
    test_end_of_frame();
    test_row_start_clear();
    test_attr_lines();
    test_rows_out_of_range();
    test_random_frames();

    s_tvalid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_rows.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
